>>> design/alpha_over_layer_compositor_core_defines.svh
// Assertion macros shared by the compositor checker.
`ifndef ALPHA_OVER_LAYER_COMPOSITOR_CORE_DEFINES_SVH
`define ALPHA_OVER_LAYER_COMPOSITOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define AOC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define AOC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/aoc_pkg.sv
// Shared types, constants and helper functions of the alpha-over compositor.
`default_nettype none
package aoc_pkg;

    localparam int unsigned NumChan = 3;

    typedef enum logic [2:0] {
        REG_OPACITY  = 3'd0,
        REG_OFFSET_X = 3'd1,
        REG_OFFSET_Y = 3'd2,
        REG_WIDTH    = 3'd3,
        REG_HEIGHT   = 3'd4
    } t_reg_idx;

    // Item state handed from one divider cell to the next.
    typedef struct packed {
        logic                    we;
        logic [35:0]             idx;
        logic [7:0]              oa;
        logic [NumChan-1:0][15:0] rem;
        logic [NumChan-1:0][7:0]  quo;
    } t_cell;

    // Exact x / 255 for any 8x8-bit product.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [15:0] t;
        t = x + {8'd0, x[15:8]} + 16'd1;
        return t[15:8];
    endfunction

endpackage
`default_nettype wire

>>> design/aoc_front.sv
// Front pipeline: placement, clipping, alpha scaling and blend numerators.
`default_nettype none
module aoc_front (
    input  wire logic                 i_clk,
    input  wire logic [4:0]           i_adv,
    input  wire logic [103:0]         i_data,
    input  wire logic [7:0]           i_opacity,
    input  wire logic signed [19:0]   i_offset_x,
    input  wire logic signed [19:0]   i_offset_y,
    input  wire logic [18:0]          i_width,
    input  wire logic [18:0]          i_height,
    output aoc_pkg::t_cell            o_cell
);

    typedef struct packed {
        logic signed [21:0] col;
        logic signed [21:0] row;
        logic [15:0]        pa;
        logic [2:0][7:0]    sc;
        logic [2:0][7:0]    dc;
        logic [7:0]         da;
    } t_s1;

    typedef struct packed {
        logic               on_canvas;
        logic [7:0]         sa;
        logic [36:0]        prod;
        logic [17:0]        col;
        logic [2:0][7:0]    sc;
        logic [2:0][7:0]    dc;
        logic [7:0]         da;
    } t_s2;

    typedef struct packed {
        logic               we;
        logic [7:0]         sa;
        logic [15:0]        pw;
        logic [35:0]        idx;
        logic [2:0][7:0]    sc;
        logic [2:0][7:0]    dc;
    } t_s3;

    typedef struct packed {
        logic               we;
        logic [7:0]         sa;
        logic [7:0]         w;
        logic [35:0]        idx;
        logic [2:0][15:0]   ps;
        logic [2:0][7:0]    dc;
    } t_s4;

    t_s1 r_s1;
    t_s2 r_s2;
    t_s3 r_s3;
    t_s4 r_s4;
    aoc_pkg::t_cell r_s5;
    t_s1 n_s1;
    t_s2 n_s2;
    t_s3 n_s3;
    t_s4 n_s4;
    aoc_pkg::t_cell n_s5;

    always_comb begin
        n_s1.col = $signed({4'd0, i_data[17:0]}) + 22'(i_offset_x);
        n_s1.row = $signed({4'd0, i_data[35:18]}) + 22'(i_offset_y);
        n_s1.pa  = i_data[67:60] * i_opacity;
        for (int k = 0; k < 3; k++) begin
            n_s1.sc[k] = i_data[36 + 8*k +: 8];
            n_s1.dc[k] = i_data[68 + 8*k +: 8];
        end
        n_s1.da = i_data[99:92];

        n_s2.on_canvas = !r_s1.col[21] && !r_s1.row[21]
                    && (r_s1.col < $signed({3'd0, i_width}))
                    && (r_s1.row < $signed({3'd0, i_height}));
        n_s2.sa   = aoc_pkg::div255(r_s1.pa);
        n_s2.prod = r_s1.row[17:0] * i_width;
        n_s2.col  = r_s1.col[17:0];
        n_s2.sc   = r_s1.sc;
        n_s2.dc   = r_s1.dc;
        n_s2.da   = r_s1.da;

        n_s3.we  = r_s2.on_canvas && (r_s2.sa != 8'd0);
        n_s3.sa  = r_s2.sa;
        n_s3.pw  = r_s2.da * (8'd255 - r_s2.sa);
        n_s3.idx = r_s2.prod[35:0] + {18'd0, r_s2.col};
        n_s3.sc  = r_s2.sc;
        n_s3.dc  = r_s2.dc;

        n_s4.we  = r_s3.we;
        n_s4.sa  = r_s3.sa;
        n_s4.w   = aoc_pkg::div255(r_s3.pw);
        n_s4.idx = r_s3.idx;
        for (int k = 0; k < 3; k++) begin
            n_s4.ps[k] = r_s3.sc[k] * r_s3.sa;
        end
        n_s4.dc = r_s3.dc;

        // The numerators never exceed 255 times the result alpha, so 16 bits hold them.
        n_s5.we  = r_s4.we;
        n_s5.idx = r_s4.idx;
        n_s5.oa  = r_s4.sa + r_s4.w;
        for (int k = 0; k < 3; k++) begin
            n_s5.rem[k] = r_s4.ps[k] + r_s4.dc[k] * r_s4.w;
            n_s5.quo[k] = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) r_s1 <= n_s1;
        if (i_adv[1]) r_s2 <= n_s2;
        if (i_adv[2]) r_s3 <= n_s3;
        if (i_adv[3]) r_s4 <= n_s4;
        if (i_adv[4]) r_s5 <= n_s5;
    end

    assign o_cell = r_s5;

endmodule
`default_nettype wire

>>> design/aoc_div_cell.sv
// One restoring-division cell: settles one quotient bit for all three channels.
`default_nettype none
module aoc_div_cell #(
    parameter int unsigned BIT = 7
) (
    input  wire logic           i_clk,
    input  wire logic           i_adv,
    input  wire aoc_pkg::t_cell i_cell,
    output aoc_pkg::t_cell      o_cell
);

    aoc_pkg::t_cell r_cell;
    aoc_pkg::t_cell n_cell;
    logic [15:0]    trial;

    always_comb begin
        trial  = {8'd0, i_cell.oa} << BIT;
        n_cell = i_cell;
        for (int k = 0; k < aoc_pkg::NumChan; k++) begin
            if (i_cell.rem[k] >= trial) begin
                n_cell.rem[k]      = i_cell.rem[k] - trial;
                n_cell.quo[k][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) r_cell <= n_cell;
    end

    assign o_cell = r_cell;

endmodule
`default_nettype wire

>>> design/alpha_over_layer_compositor_core.sv
// Throughput: one item per cycle when the output is not stalled; five front stages,
// eight division cells (one quotient bit each) and the output register each hold one item.
// Every stage can refill while a later one waits, so no bubble is lost.
// Reset clears all valid bits and loads the register defaults
// (opacity 255, offsets 0, canvas size MAX_DIMENSION).
`default_nettype none
module alpha_over_layer_compositor_core #(
    parameter int MAX_DIMENSION = 262144
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // src_x, src_y, src_red, src_green, src_blue, src_alpha,
    // dst_red, dst_green, dst_blue, dst_alpha, 4 zero bits
    input  wire logic [103:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // pixel_index, out_red, out_green, out_blue, out_alpha, 4 zero bits
    output logic [71:0]       m_axis_tdata,
    // write_enable
    output logic              m_axis_tuser,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_addr,
    input  wire logic [19:0]  i_cfg_wdata
);

    localparam int NStage = 14;
    localparam int NFront = 5;
    localparam logic signed [19:0] OfsMax = 20'(MAX_DIMENSION);
    localparam logic signed [19:0] OfsMin = 20'(-MAX_DIMENSION);
    localparam logic [18:0]        DimMax = 19'(MAX_DIMENSION);

    logic [7:0]         r_opacity;
    logic signed [19:0] r_offset_x;
    logic signed [19:0] r_offset_y;
    logic [18:0]        r_width;
    logic [18:0]        r_height;
    logic signed [19:0] n_offset;
    logic [18:0]        n_dim;

    logic [NStage-1:0]  r_vld;
    logic [NStage-1:0]  adv;
    aoc_pkg::t_cell     chain [0:8];
    logic [71:0]        r_out;
    logic               r_out_we;

    always_comb begin
        n_offset = $signed(i_cfg_wdata);
        if ($signed(i_cfg_wdata) > OfsMax) n_offset = OfsMax;
        if ($signed(i_cfg_wdata) < OfsMin) n_offset = OfsMin;
        n_dim = (i_cfg_wdata[18:0] > DimMax) ? DimMax : i_cfg_wdata[18:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opacity  <= 8'd255;
            r_offset_x <= 20'sd0;
            r_offset_y <= 20'sd0;
            r_width    <= DimMax;
            r_height   <= DimMax;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                aoc_pkg::REG_OPACITY:  r_opacity  <= i_cfg_wdata[7:0];
                aoc_pkg::REG_OFFSET_X: r_offset_x <= n_offset;
                aoc_pkg::REG_OFFSET_Y: r_offset_y <= n_offset;
                aoc_pkg::REG_WIDTH:    r_width    <= n_dim;
                aoc_pkg::REG_HEIGHT:   r_height   <= n_dim;
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or its content moves on this cycle.
    always_comb begin
        adv[NStage-1] = !r_vld[NStage-1] || m_axis_tready;
        for (int i = NStage-2; i >= 0; i--) begin
            adv[i] = !r_vld[i] || adv[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= s_axis_tvalid;
            for (int i = 1; i < NStage; i++) begin
                if (adv[i]) r_vld[i] <= r_vld[i-1];
            end
        end
    end

    aoc_front u_front (
        .i_clk      (i_clk),
        .i_adv      (adv[NFront-1:0]),
        .i_data     (s_axis_tdata),
        .i_opacity  (r_opacity),
        .i_offset_x (r_offset_x),
        .i_offset_y (r_offset_y),
        .i_width    (r_width),
        .i_height   (r_height),
        .o_cell     (chain[0])
    );

    for (genvar g = 0; g < 8; g++) begin : g_cell
        aoc_div_cell #(.BIT(7 - g)) u_cell (
            .i_clk  (i_clk),
            .i_adv  (adv[NFront + g]),
            .i_cell (chain[g]),
            .o_cell (chain[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (adv[NStage-1]) begin
            r_out_we <= chain[8].we;
            if (chain[8].we) begin
                r_out <= {4'd0, chain[8].oa, chain[8].quo[2], chain[8].quo[1],
                          chain[8].quo[0], chain[8].idx};
            end else begin
                r_out <= '0;
            end
        end
    end

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = r_vld[NStage-1];
    assign m_axis_tdata  = r_out;
    assign m_axis_tuser  = r_out_we;

endmodule
`default_nettype wire

>>> design/aoc_checker.sv
// Port-level checker for the compositor, bound to the top level.
`default_nettype none
`include "alpha_over_layer_compositor_core_defines.svh"
module aoc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [71:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    `AOC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `AOC_ASSERT_NOW(a_nowrite_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 72'd0)
    `AOC_ASSERT_NOW(a_write_alpha, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata[67:60] != 8'd0)

endmodule

bind alpha_over_layer_compositor_core aoc_checker u_aoc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

>>> tb/sv/tb_alpha_over_layer_compositor_core.sv
// Self-checking testbench for the alpha-over layer compositor core.
`default_nettype none
module tb_alpha_over_layer_compositor_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MaxDim = 262144;

    typedef struct packed {
        logic        we;
        logic [35:0] idx;
        logic [7:0]  r, g, b, a;
    } t_pix;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_addr = '0;
    logic [19:0]  i_cfg_wdata = '0;

    alpha_over_layer_compositor_core dut (.*);

    // Predictor copy of the register file.
    logic [7:0]        opacity;
    logic signed [20:0] off_x, off_y;
    logic [18:0]       cw, ch;

    t_pix blended_q[$];
    int   errors = 0;
    int   src_idle = 0, dst_idle = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic [103:0] pack_px(input logic [17:0] x, y,
                                             input logic [31:0] s, d);
        return {4'd0, d[31:24], d[23:16], d[15:8], d[7:0],
                s[31:24], s[23:16], s[15:8], s[7:0], y, x};
    endfunction

    function automatic t_pix blend(input logic [103:0] t);
        t_pix p;
        longint col, row;
        int unsigned sa, w, oa, sc, dc;
        p = '0;
        col = longint'(t[17:0]) + longint'(off_x);
        row = longint'(t[35:18]) + longint'(off_y);
        if (col < 0 || row < 0 || col >= longint'(cw) || row >= longint'(ch)) return p;
        sa = t[67:60] * opacity / 255;
        if (sa == 0) return p;
        w = t[99:92] * (255 - sa) / 255;
        oa = sa + w;
        p.we = 1'b1;
        p.idx = 36'(row * longint'(cw) + col);
        for (int k = 0; k < 3; k++) begin
            sc = t[36+8*k +: 8];
            dc = t[68+8*k +: 8];
            case (k)
                0: p.r = 8'((sc * sa + dc * w) / oa);
                1: p.g = 8'((sc * sa + dc * w) / oa);
                default: p.b = 8'((sc * sa + dc * w) / oa);
            endcase
        end
        p.a = 8'(oa);
        return p;
    endfunction

    task automatic write_reg(input aoc_pkg::t_reg_idx idx, input logic [19:0] v);
        logic signed [19:0] sv;
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= v;
        sv = v;
        case (idx)
            aoc_pkg::REG_OPACITY: opacity = v[7:0];
            aoc_pkg::REG_OFFSET_X:
                off_x = 21'(sv > MaxDim ? MaxDim : (sv < -MaxDim ? -MaxDim : sv));
            aoc_pkg::REG_OFFSET_Y:
                off_y = 21'(sv > MaxDim ? MaxDim : (sv < -MaxDim ? -MaxDim : sv));
            aoc_pkg::REG_WIDTH: cw = 19'(v[18:0] > MaxDim ? MaxDim : v[18:0]);
            aoc_pkg::REG_HEIGHT: ch = 19'(v[18:0] > MaxDim ? MaxDim : v[18:0]);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Sends one item; the expectation is queued when it is accepted.
    task automatic send_px(input logic [103:0] t, input bit has_exp, input t_pix exp_px);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= t;
        do @(posedge i_clk); while (!s_axis_tready);
        blended_q.insert(blended_q.size(), has_exp ? exp_px : blend(t));
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (blended_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    always @(negedge i_clk) m_axis_tready <= ($urandom_range(99) >= dst_idle);

    always @(posedge i_clk) begin
        t_pix got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser, m_axis_tdata[35:0], m_axis_tdata[43:36],
                   m_axis_tdata[51:44], m_axis_tdata[59:52], m_axis_tdata[67:60]};
            if (blended_q.size() == 0) begin
                errors++;
                $display("%0t expected no result actual %h", $realtime, got);
            end else begin
                want = blended_q.pop_front();
                if (got.we !== want.we || got.idx !== want.idx || got.r !== want.r ||
                    got.g !== want.g || got.b !== want.b || got.a !== want.a) begin
                    errors++;
                    $display("%0t expected %h actual %h", $realtime, want, got);
                end
            end
        end
    end

    typedef struct {
        logic [17:0] x, y;
        logic [31:0] s, d;
        bit          has_exp;
        t_pix        exp_px;
    } t_row;

    initial begin
        t_row rows[$];
        int   n;
        logic [17:0] x, y;
        opacity = 8'd255; off_x = 0; off_y = 0; cw = MaxDim; ch = MaxDim;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table; a few rows carry an expectation read directly.
        rows.insert(rows.size(), '{0, 0, 32'hFF00_00FF, 0, 1, '{1, 0, 8'hFF, 0, 0, 8'hFF}});
        rows.insert(rows.size(), '{0, 0, 32'h00FF_FFFF, 32'hFFFF_FFFF, 1, '0});
        rows.insert(rows.size(), '{18'h3FFFF, 18'h3FFFF, 32'hFFFF_FFFF, 0, 0, '0});
        rows.insert(rows.size(), '{5, 7, 32'h80FF_8000, 32'hFF00_80FF, 0, '0});
        rows.insert(rows.size(), '{1, 0, 32'h0100_0000, 32'hFFFF_FFFF, 0, '0});
        rows.insert(rows.size(), '{3, 3, 32'hFE12_3456, 32'h0165_4321, 0, '0});
        foreach (rows[i]) send_px(pack_px(rows[i].x, rows[i].y, rows[i].s, rows[i].d),
                                  rows[i].has_exp, rows[i].exp_px);
        drain();
        write_reg(aoc_pkg::REG_WIDTH, 20'd0);
        send_px(pack_px(0, 0, '1, '1), 1, '0);
        drain();
        write_reg(aoc_pkg::REG_WIDTH, 20'h7FFFF);
        write_reg(aoc_pkg::REG_HEIGHT, 20'd1);
        write_reg(aoc_pkg::REG_OFFSET_X, 20'h7FFFF);
        write_reg(aoc_pkg::REG_OFFSET_Y, 20'h80000);
        write_reg(aoc_pkg::REG_OPACITY, 20'd0);
        write_reg(aoc_pkg::t_reg_idx'(3'd7), 20'hFFFFF);
        send_px(pack_px(1, 0, '1, '1), 1, '0);
        send_px(pack_px(18'h3FFFF, 18'h3FFFF, '1, '1), 0, '0);
        drain();
        write_reg(aoc_pkg::REG_OPACITY, 20'd255);
        write_reg(aoc_pkg::REG_OFFSET_X, 20'hC0000);
        write_reg(aoc_pkg::REG_OFFSET_Y, 20'h40001);
        send_px(pack_px(18'h3FFFF, 0, '1, '1), 0, '0);
        send_px(pack_px(18'h3FFFF, 18'h3FFFF, 32'h7F01_02FE, 32'h8011_2233), 0, '0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 3)
                0: begin src_idle = 20; dst_idle = 67; end
                1: begin src_idle = 67; dst_idle = 20; end
                default: begin src_idle = 0; dst_idle = 0; end
            endcase
            write_reg(aoc_pkg::REG_OPACITY, ph == 0 ? 20'd255 : 20'($urandom_range(255)));
            write_reg(aoc_pkg::REG_OFFSET_X, ph < 3 ? 20'($signed($urandom_range(64)) - 32)
                                                     : 20'($urandom));
            write_reg(aoc_pkg::REG_OFFSET_Y, ph < 3 ? 20'($signed($urandom_range(64)) - 32)
                                                     : 20'($urandom));
            write_reg(aoc_pkg::REG_WIDTH, ph < 3 ? 20'($urandom_range(200, 1)) : 20'($urandom));
            write_reg(aoc_pkg::REG_HEIGHT, ph < 3 ? 20'($urandom_range(200, 1)) : 20'($urandom));
            n = 175;
            for (int i = 0; i < n; i++) begin
                // Mostly coordinates near the canvas, sometimes anywhere.
                if ($urandom_range(3) == 0) begin
                    x = 18'($urandom); y = 18'($urandom);
                end else begin
                    x = 18'($urandom_range(240)); y = 18'($urandom_range(240));
                end
                send_px(pack_px(x, y, $urandom, $urandom), 0, '0);
            end
            drain();
        end
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
+incdir+design
design/aoc_pkg.sv
design/aoc_front.sv
design/aoc_div_cell.sv
design/alpha_over_layer_compositor_core.sv
design/aoc_checker.sv
tb/sv/tb_alpha_over_layer_compositor_core.sv
